/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the priority queue
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SMPQ_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("smpq assertion failed");

// next-cycle implication, disabled while reset is low
`define SMPQ_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("smpq assertion failed");

`endif

/* sv/smpq_pkg.sv */
// ----------------------------------------------------------------------------
// smpq_pkg
// types, codes and defaults shared by the priority queue files
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smpq_pkg;

  localparam int DEF_CAPACITY      = 16;
  localparam int DEF_PRIORITY_BITS = 16;

  localparam int DATA_W     = 32;
  localparam int PRIO_FLD_W = 16;
  localparam int OCC_W      = 5;
  localparam int STATUS_W   = 2;

  localparam logic signed [DATA_W-1:0] EMPTY_DATA = 32'hFFFF_FFFF;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_PEND
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic send;
  } dp_cmd_t;

endpackage

/* sv/smpq_if.sv */
// ----------------------------------------------------------------------------
// smpq channel interfaces
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface smpq_in_if;
  import smpq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [DATA_W-1:0] data_in;
  logic [PRIO_FLD_W-1:0]    priority_req;

  modport source (output valid, output operation, output data_in, output priority_req,
                  input ready);
  modport sink (input valid, input operation, input data_in, input priority_req,
                output ready);
endinterface

interface smpq_out_if;
  import smpq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] data_out;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output status, output data_out, output occupancy,
                  input ready);
  modport sink (input valid, input status, input data_out, input occupancy,
                output ready);
endinterface

/* sv/smpq_ctrl.sv */
// ----------------------------------------------------------------------------
// smpq_ctrl
// sequencer for the priority queue: capture, execute, hand off result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smpq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output smpq_pkg::dp_cmd_t cmd
);
  import smpq_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) state_nxt = CS_EXEC;
      end
      CS_EXEC: state_nxt = CS_PEND;
      CS_PEND: begin
        if (slot_free) state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.send    = 1'b0;
    unique case (state_r)
      CS_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      CS_EXEC: cmd.exec = 1'b1;
      CS_PEND: cmd.send = slot_free;
      default: ;
    endcase
  end

  // result register holds until the sink takes the beat
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.send) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* sv/smpq_dp.sv */
// ----------------------------------------------------------------------------
// smpq_dp
// sorted cell array, request latch, pending and output result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smpq_dp #(
  parameter int CAPACITY      = smpq_pkg::DEF_CAPACITY,
  parameter int PRIORITY_BITS = smpq_pkg::DEF_PRIORITY_BITS,
  localparam int CNT_W        = $clog2(CAPACITY + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  smpq_pkg::dp_cmd_t                  cmd,
  input  logic                               operation,
  input  logic signed [smpq_pkg::DATA_W-1:0] data_in,
  input  logic [smpq_pkg::PRIO_FLD_W-1:0]    priority_req,
  output logic [smpq_pkg::STATUS_W-1:0]      status,
  output logic signed [smpq_pkg::DATA_W-1:0] data_out,
  output logic [smpq_pkg::OCC_W-1:0]         occupancy,
  output logic [CNT_W-1:0]                   count
);
  import smpq_pkg::*;

  logic                     req_op_r;
  logic signed [DATA_W-1:0] req_data_r;
  logic [PRIORITY_BITS-1:0] req_pri_r;
  logic [31:0]              pri_ext;

  logic signed [DATA_W-1:0] cell_data_r [CAPACITY];
  logic [PRIORITY_BITS-1:0] cell_pri_r  [CAPACITY];
  logic [CNT_W-1:0]         count_r, count_nxt;

  logic [CAPACITY-1:0]      behind;
  logic                     full, empty, do_ins, do_deq;

  status_t                  pend_status_r, pend_status_nxt;
  logic signed [DATA_W-1:0] pend_data_r, pend_data_nxt;
  logic [OCC_W-1:0]         pend_occ_r;

  logic [STATUS_W-1:0]      out_status_r;
  logic signed [DATA_W-1:0] out_data_r;
  logic [OCC_W-1:0]         out_occ_r;

  // priority bits above PRIORITY_BITS are dropped, missing ones read as zero
  assign pri_ext = {{(32 - PRIO_FLD_W){1'b0}}, priority_req};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op_r   <= operation;
      req_data_r <= data_in;
      req_pri_r  <= pri_ext[PRIORITY_BITS-1:0];
    end
  end

  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);
  assign do_ins = cmd.exec && (req_op_r == OP_ENQ) && !full;
  assign do_deq = cmd.exec && (req_op_r == OP_DEQ) && !empty;

  // a cell sits behind the new entry when it is unused or strictly larger
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cmp
    assign behind[k] = (CNT_W'(k) >= count_r) || (cell_pri_r[k] > req_pri_r);
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    always_ff @(posedge clk) begin
      if (do_ins && behind[k]) begin
        if (k == 0) begin
          cell_data_r[k] <= req_data_r;
          cell_pri_r[k]  <= req_pri_r;
        end else if (!behind[(k == 0) ? 0 : k - 1]) begin
          cell_data_r[k] <= req_data_r;
          cell_pri_r[k]  <= req_pri_r;
        end else begin
          cell_data_r[k] <= cell_data_r[(k == 0) ? 0 : k - 1];
          cell_pri_r[k]  <= cell_pri_r[(k == 0) ? 0 : k - 1];
        end
      end else if (do_deq && (k < CAPACITY - 1)) begin
        cell_data_r[k] <= cell_data_r[(k < CAPACITY - 1) ? k + 1 : k];
        cell_pri_r[k]  <= cell_pri_r[(k < CAPACITY - 1) ? k + 1 : k];
      end
    end
  end

  always_comb begin
    count_nxt       = count_r;
    pend_status_nxt = STAT_OK;
    pend_data_nxt   = '0;
    if (req_op_r == OP_ENQ) begin
      if (full) pend_status_nxt = STAT_FULL;
      else count_nxt = count_r + CNT_W'(1);
    end else begin
      if (empty) begin
        pend_status_nxt = STAT_EMPTY;
        pend_data_nxt   = EMPTY_DATA;
      end else begin
        pend_data_nxt = cell_data_r[0];
        count_nxt     = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pend_status_r <= pend_status_nxt;
      pend_data_r   <= pend_data_nxt;
      pend_occ_r    <= OCC_W'(count_nxt);
    end
    if (cmd.send) begin
      out_status_r <= pend_status_r;
      out_data_r   <= pend_data_r;
      out_occ_r    <= pend_occ_r;
    end
  end

  assign status    = out_status_r;
  assign data_out  = out_data_r;
  assign occupancy = out_occ_r;
  assign count     = count_r;

endmodule

/* sv/stable_min_priority_queue.sv */
// ----------------------------------------------------------------------------
// stable_min_priority_queue
// result path: request latch, pending result register, output result register
// requests: a new request is accepted only in idle, once the capture/execute/hand-off
//   sequence of the last one is through; the hand-off waits while the sink holds the result register
// reset: synchronous active-low rst_n clears the entry count and handshake state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stable_min_priority_queue #(
  parameter int CAPACITY      = smpq_pkg::DEF_CAPACITY,
  parameter int PRIORITY_BITS = smpq_pkg::DEF_PRIORITY_BITS
) (
  input logic        clk,
  input logic        rst_n,
  smpq_in_if.sink    in_chan,
  smpq_out_if.source out_chan
);
  import smpq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  dp_cmd_t          cmd;
  logic [CNT_W-1:0] count;

  smpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  smpq_dp #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .operation    (in_chan.operation),
    .data_in      (in_chan.data_in),
    .priority_req (in_chan.priority_req),
    .status       (out_chan.status),
    .data_out     (out_chan.data_out),
    .occupancy    (out_chan.occupancy),
    .count        (count)
  );

  // busy after every accepted request beat
  `SMPQ_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_chan.valid && in_chan.ready, !in_chan.ready)
  // execute step only right after a capture
  `SMPQ_ASSERT_IMP(a_exec_after_capture, clk, rst_n, cmd.exec, $past(cmd.capture))
  // count never passes capacity
  `SMPQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count <= CNT_W'(CAPACITY))
  // a refused enqueue reports zero data
  `SMPQ_ASSERT_IMP(a_full_data_zero, clk, rst_n, out_chan.valid && (out_chan.status == STAT_FULL), out_chan.data_out == '0)

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Checks the sorted priority queue against a software copy of the queue.
// Runs a short directed sequence: empty dequeue, extreme data and priority
// values, priority ties, filling to full and refused enqueues. It then runs
// random fill and drain phases with random content. Every result beat is
// compared field by field with the predicted reply, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import smpq_pkg::*;

  localparam int CAP        = DEF_CAPACITY;
  localparam int PRIO_BITS  = DEF_PRIORITY_BITS;
  localparam int NUM_RANDOM = 1850;
  localparam int STALL_MAX  = 2000;
  localparam int DRAIN_WAIT = 20;

  typedef struct {
    op_t                      op;
    logic signed [DATA_W-1:0] data;
    logic [PRIO_FLD_W-1:0]    prio;
  } request_t;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic [OCC_W-1:0]         occ;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n;

  smpq_in_if  req_if ();
  smpq_out_if rsp_if ();

  stable_min_priority_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if.sink),
    .out_chan (rsp_if.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // software copy of the sorted store
  logic signed [DATA_W-1:0] sorted_data [CAP];
  logic [PRIO_BITS-1:0]     sorted_prio [CAP];
  int                       sorted_count;

  request_t requests_to_send[$];
  reply_t   expected_replies[$];
  request_t on_bus;
  reply_t   want;
  int       gen_count;
  int       errors;
  int       cyc;
  int       stall_cycles;
  logic     quiet;

  // model one accepted request and queue the reply it must produce
  task automatic apply_queue_op(input request_t r);
    reply_t               rep;
    int                   pos;
    logic [PRIO_BITS-1:0] p;
    p = r.prio[PRIO_BITS-1:0];
    rep.data = '0;
    if (r.op == OP_ENQ) begin
      if (sorted_count >= CAP) begin
        rep.status = STAT_FULL;
      end else begin
        pos = 0;
        while (pos < sorted_count && sorted_prio[pos] <= p) pos++;
        for (int k = sorted_count; k > pos; k--) begin
          sorted_data[k] = sorted_data[k-1];
          sorted_prio[k] = sorted_prio[k-1];
        end
        sorted_data[pos] = r.data;
        sorted_prio[pos] = p;
        sorted_count++;
        rep.status = STAT_OK;
      end
    end else if (sorted_count == 0) begin
      rep.status = STAT_EMPTY;
      rep.data   = EMPTY_DATA;
    end else begin
      rep.status = STAT_OK;
      rep.data   = sorted_data[0];
      for (int k = 1; k < sorted_count; k++) begin
        sorted_data[k-1] = sorted_data[k];
        sorted_prio[k-1] = sorted_prio[k];
      end
      sorted_count--;
    end
    rep.occ = OCC_W'(sorted_count);
    expected_replies.push_back(rep);
  endtask

  task automatic add_request(input op_t op, input logic [DATA_W-1:0] d,
                             input logic [PRIO_FLD_W-1:0] p);
    request_t r;
    r.op   = op;
    r.data = d;
    r.prio = p;
    requests_to_send.push_back(r);
    if (op == OP_ENQ && gen_count < CAP) gen_count++;
    else if (op == OP_DEQ && gen_count > 0) gen_count--;
  endtask

  function automatic logic [PRIO_FLD_W-1:0] pick_prio();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return PRIO_FLD_W'($urandom_range(0, 3));
    else if (sel < 80) return PRIO_FLD_W'($urandom_range(0, 255));
    else return PRIO_FLD_W'($urandom);
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // no random idling on either side during this window
  always @(posedge clk) begin
    cyc   <= cyc + 1;
    quiet <= (cyc >= 1500 && cyc < 2700);
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) apply_queue_op(on_bus);
      if (!req_if.valid || req_if.ready) begin
        if (requests_to_send.size() != 0 && (quiet || $urandom_range(0, 99) >= 12)) begin
          on_bus = requests_to_send.pop_front();
          req_if.valid        <= 1'b1;
          req_if.operation    <= on_bus.op;
          req_if.data_in      <= on_bus.data;
          req_if.priority_req <= on_bus.prio;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: result beat with no reply expected, actual status %0d data %0d occ %0d",
                   $time, rsp_if.status, rsp_if.data_out, rsp_if.occupancy);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          if (rsp_if.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, rsp_if.status);
            errors++;
          end
          if (rsp_if.data_out !== want.data) begin
            $display("%0t: data_out mismatch, expected %0d, actual %0d",
                     $time, want.data, rsp_if.data_out);
            errors++;
          end
          if (rsp_if.occupancy !== want.occ) begin
            $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                     $time, want.occ, rsp_if.occupancy);
            errors++;
          end
        end
      end
      rsp_if.ready <= quiet || $urandom_range(0, 99) >= 12;
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic filling;
    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.operation    = OP_ENQ;
    req_if.data_in      = '0;
    req_if.priority_req = '0;
    rsp_if.ready        = 1'b0;
    sorted_count        = 0;
    gen_count           = 0;
    errors              = 0;
    cyc                 = 0;
    quiet               = 1'b0;
    stall_cycles        = 0;

    // directed: empty dequeue, extremes, ties, fill to full, refused enqueues, dequeues
    add_request(OP_DEQ, 32'hFFFF_FFFF, 16'hFFFF);
    add_request(OP_ENQ, 32'h7FFF_FFFF, 16'hFFFF);
    add_request(OP_ENQ, 32'h8000_0000, 16'h0000);
    add_request(OP_ENQ, 32'hFFFF_FFFF, 16'hFFFF);
    add_request(OP_ENQ, 32'h0000_0000, 16'h0000);
    for (int i = 0; i < CAP - 4; i++)
      add_request(OP_ENQ, 32'h5A5A_0000 + i, PRIO_FLD_W'(i % 3));
    add_request(OP_ENQ, 32'h1234_5678, 16'h0000);
    add_request(OP_ENQ, 32'hFFFF_FFFF, 16'hFFFF);
    for (int i = 0; i < 3; i++) add_request(OP_DEQ, 32'h0000_0000, 16'h0000);

    // random fill and drain phases
    filling = 1'b0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (gen_count == 0) filling = 1'b1;
      else if (gen_count == CAP && $urandom_range(0, 2) == 0) filling = 1'b0;
      else if ($urandom_range(0, 99) < 4) filling = !filling;
      if ((filling && $urandom_range(0, 99) < 80) || (!filling && $urandom_range(0, 99) < 20))
        add_request(OP_ENQ, pick_data(), pick_prio());
      else
        add_request(OP_DEQ, $urandom, PRIO_FLD_W'($urandom));
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (requests_to_send.size() != 0 || req_if.valid || expected_replies.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* stable_min_priority_queue.f */
+incdir+sv
sv/smpq_pkg.sv
sv/smpq_if.sv
sv/smpq_ctrl.sv
sv/smpq_dp.sv
sv/stable_min_priority_queue.sv
test/tb.sv
